// ===== src/ssq_pkg.sv =====
// shared types, state codes and the squaring function for the sorted-squares unit
`timescale 1ns / 1ps

package ssq_pkg;

    localparam int VALUE_W  = 16;
    localparam int SQUARE_W = 31;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } t_in_word;

    typedef struct packed {
        logic [SQUARE_W-1:0] square;
        logic                run_end;
        logic                overflowed;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_L,
        ST_LOAD_H,
        ST_MERGE,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // -32768 squares to 2^30, still below bit 31
    function automatic logic [SQUARE_W-1:0] square_of(input logic signed [VALUE_W-1:0] v);
        logic signed [2*VALUE_W-1:0] p;
        begin
            p = v * v;
            return p[SQUARE_W-1:0];
        end
    endfunction

endpackage

// ===== src/ssq_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module ssq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sorted_squares_two_pointer_unit.sv =====
// top level: collects a sorted run, merges squares from both ends, emits them ascending
//
// usage: words arrive on the input channel (i_in_valid / o_in_stall), one signed
// value each, final_item set on the last word of a run. every word is squared on
// entry and written to the element ram; up to MAX_LEN words are kept and later
// ones are dropped, which sets overflowed on every result of that run.
// a non-final word gives no result. after the final word the input is stalled
// while the unit works: it preloads both ends (ST_LOAD_L, ST_LOAD_H), then runs
// the two-pointer merge into the result ram (one element ram read port, compare
// against the held end), then reads each result from the result ram (ST_EMIT_RD,
// ST_EMIT_WR), one result at a time, from the lowest address upward.
// results leave through an output register (o_out_valid / i_out_stall), in
// ascending order, run_end on the last one. while the receiver stalls, the
// current result holds and the unit waits; once the last result is in the
// output register the input is taken again, so a new run may start while that
// result still waits. reset clears the fill count, the overflow flag, the state
// and the output valid; ram contents are left as they are.
`timescale 1ns / 1ps

module sorted_squares_two_pointer_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssq_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ssq_pkg::t_out_word o_out_word
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = ssq_pkg::SQUARE_W;

    ssq_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_run_ovf, n_run_ovf;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_e, n_e;
    logic [SW-1:0] r_sl, n_sl;
    logic [SW-1:0] r_sh, n_sh;
    logic          r_pend_h, n_pend_h;
    logic          r_out_valid, n_out_valid;
    ssq_pkg::t_out_word r_out, n_out;

    logic          in_acc;
    logic          has_room;
    logic          out_free;
    logic [SW-1:0] cur_l, cur_h;
    logic          take_l;

    logic          el_we;
    logic [AW-1:0] el_waddr;
    logic [SW-1:0] el_wdata;
    logic [AW-1:0] el_raddr;
    logic [SW-1:0] el_rdata;

    logic          sq_we;
    logic [AW-1:0] sq_waddr;
    logic [SW-1:0] sq_wdata;
    logic          sq_re;
    logic [AW-1:0] sq_raddr;
    logic [SW-1:0] sq_rdata;

    assign o_in_stall = (r_state != ssq_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign has_room   = (r_count < CW'(MAX_LEN));
    assign out_free   = !r_out_valid || !i_out_stall;

    // squares of stored elements, indexed by arrival order
    ssq_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_element_ram (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (el_waddr),
        .i_wdata (el_wdata),
        .i_re    (1'b1),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    // merged squares, ascending by address
    ssq_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_result_ram (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_waddr),
        .i_wdata (sq_wdata),
        .i_re    (sq_re),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssq_pkg::ST_IDLE: begin
                if (in_acc && i_in_word.final_item) begin
                    n_state = ssq_pkg::ST_LOAD_L;
                end
            end
            ssq_pkg::ST_LOAD_L: n_state = ssq_pkg::ST_LOAD_H;
            ssq_pkg::ST_LOAD_H: n_state = ssq_pkg::ST_MERGE;
            ssq_pkg::ST_MERGE: begin
                if (r_slot == '0) begin
                    n_state = ssq_pkg::ST_EMIT_RD;
                end
            end
            ssq_pkg::ST_EMIT_RD: n_state = ssq_pkg::ST_EMIT_WR;
            ssq_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    if (r_e == r_n - CW'(1)) begin
                        n_state = ssq_pkg::ST_IDLE;
                    end else begin
                        n_state = ssq_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ssq_pkg::ST_IDLE;
        endcase
    end

    // the end not pending from the ram is held in r_sl or r_sh
    assign cur_l  = r_pend_h ? r_sl : el_rdata;
    assign cur_h  = r_pend_h ? el_rdata : r_sh;
    assign take_l = (cur_l >= cur_h);

    // datapath and ram control
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_run_ovf   = r_run_ovf;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_slot      = r_slot;
        n_e         = r_e;
        n_sl        = r_sl;
        n_sh        = r_sh;
        n_pend_h    = r_pend_h;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        el_we    = 1'b0;
        el_waddr = r_count[AW-1:0];
        el_wdata = ssq_pkg::square_of(i_in_word.value);
        el_raddr = '0;
        sq_we    = 1'b0;
        sq_waddr = r_slot[AW-1:0];
        sq_wdata = take_l ? cur_l : cur_h;
        sq_re    = 1'b0;
        sq_raddr = r_e[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ssq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (has_room) begin
                        el_we   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_word.final_item) begin
                        n_n       = n_count;
                        n_run_ovf = n_ovf;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_lo      = '0;
                        n_hi      = n_n - CW'(1);
                        n_slot    = n_n - CW'(1);
                        n_e       = '0;
                    end
                end
            end
            ssq_pkg::ST_LOAD_L: begin
                el_raddr = '0;
            end
            ssq_pkg::ST_LOAD_H: begin
                n_sl     = el_rdata;
                el_raddr = r_hi[AW-1:0];
                n_pend_h = 1'b1;
            end
            ssq_pkg::ST_MERGE: begin
                sq_we  = 1'b1;
                n_slot = r_slot - CW'(1);
                if (take_l) begin
                    n_lo     = r_lo + CW'(1);
                    el_raddr = n_lo[AW-1:0];
                    n_sh     = cur_h;
                    n_pend_h = 1'b0;
                end else begin
                    n_hi     = r_hi - CW'(1);
                    el_raddr = n_hi[AW-1:0];
                    n_sl     = cur_l;
                    n_pend_h = 1'b1;
                end
            end
            ssq_pkg::ST_EMIT_RD: begin
                sq_re = 1'b1;
            end
            ssq_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.square     = sq_rdata;
                    n_out.run_end    = (r_e == r_n - CW'(1));
                    n_out.overflowed = r_run_ovf;
                    n_e              = r_e + CW'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssq_pkg::ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_ovf <= n_run_ovf;
        r_n       <= n_n;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_slot    <= n_slot;
        r_e       <= n_e;
        r_sl      <= n_sl;
        r_sh      <= n_sh;
        r_pend_h  <= n_pend_h;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // consumed from both ends always matches slots filled
    a_pointer_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssq_pkg::ST_MERGE) |-> (CW'(r_lo + r_slot) == r_hi))
        else $error("merge pointers out of balance");

    a_final_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.final_item) |=>
            (r_state == ssq_pkg::ST_LOAD_L && r_count == '0 && !r_ovf))
        else $error("final word did not start a run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("fill count beyond capacity");

    a_emit_only_after_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssq_pkg::ST_MERGE && r_slot == '0) |=> (r_state == ssq_pkg::ST_EMIT_RD))
        else $error("merge did not hand over to emit");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the sorted-squares two-pointer unit
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_W     = ssq_pkg::VALUE_W;
    localparam int SQUARE_W    = ssq_pkg::SQUARE_W;
    localparam int MAX_LEN     = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 250;
    localparam int N_DIR       = 23;
    localparam int RAND_ITEMS  = 345;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      fin;
        logic                      known;
        logic [SQUARE_W-1:0]       sq;
    } t_dir_row;

    // single-word runs carry their square typed in, the rest go through the predictor
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{-16'sd32768, 1'b1, 1'b1, 31'd1073741824},
        '{ 16'sd32767, 1'b1, 1'b1, 31'd1073676289},
        '{ 16'sd0,     1'b1, 1'b1, 31'd0},
        '{-16'sd1,     1'b1, 1'b1, 31'd1},
        '{-16'sd5,     1'b0, 1'b0, 31'd0},
        '{-16'sd3,     1'b0, 1'b0, 31'd0},
        '{-16'sd3,     1'b0, 1'b0, 31'd0},
        '{ 16'sd0,     1'b0, 1'b0, 31'd0},
        '{ 16'sd3,     1'b0, 1'b0, 31'd0},
        '{ 16'sd5,     1'b1, 1'b0, 31'd0},
        '{-16'sd32768, 1'b0, 1'b0, 31'd0},
        '{-16'sd200,   1'b0, 1'b0, 31'd0},
        '{-16'sd7,     1'b1, 1'b0, 31'd0},
        '{ 16'sd1,     1'b0, 1'b0, 31'd0},
        '{ 16'sd2,     1'b0, 1'b0, 31'd0},
        '{ 16'sd32767, 1'b1, 1'b0, 31'd0},
        '{ 16'sd9,     1'b0, 1'b0, 31'd0},
        '{-16'sd2,     1'b0, 1'b0, 31'd0},
        '{ 16'sd40,    1'b0, 1'b0, 31'd0},
        '{-16'sd30,    1'b0, 1'b0, 31'd0},
        '{ 16'sd1,     1'b1, 1'b0, 31'd0},
        '{-16'sd4,     1'b0, 1'b0, 31'd0},
        '{ 16'sd4,     1'b1, 1'b0, 31'd0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               o_in_stall;
    ssq_pkg::t_in_word  in_word;
    logic               o_out_valid;
    logic               out_stall;
    ssq_pkg::t_out_word o_out_word;

    sorted_squares_two_pointer_unit #(
        .MAX_LEN (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    // predictor state: the run collected so far
    logic signed [VALUE_W-1:0] run_elems [MAX_LEN];
    logic [6:0]                run_count;
    logic                      run_dropped;

    ssq_pkg::t_out_word pending_squares [$];
    ssq_pkg::t_out_word want_word;
    int        mismatch_cnt;
    int        words_sent;
    int        idle_pct;
    int        stall_pct;
    int        hold_reqs;
    int        hold_served;
    int        hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [SQUARE_W-1:0] mag_squared(input logic signed [VALUE_W-1:0] v);
        int m;
        m = v;
        if (m < 0)
            m = -m;
        return SQUARE_W'(m * m);
    endfunction

    // track one accepted word; on the final word merge both ends into ascending squares
    function automatic void absorb_word(input ssq_pkg::t_in_word w, input logic known,
                                        input logic [SQUARE_W-1:0] known_sq);
        logic [SQUARE_W-1:0] slots [MAX_LEN];
        logic [SQUARE_W-1:0] sl, sh;
        int n, lo, hi;
        if (run_count < MAX_LEN) begin
            run_elems[run_count[5:0]] = w.value;
            run_count = run_count + 1'b1;
        end else begin
            run_dropped = 1'b1;
        end
        if (!w.final_item)
            return;
        n  = run_count;
        lo = 0;
        hi = n - 1;
        for (int k = 0; k < n; k++) begin
            sl = mag_squared(run_elems[lo]);
            sh = mag_squared(run_elems[hi]);
            // tie goes to the left end
            if (sl >= sh) begin
                slots[n-1-k] = sl;
                lo++;
            end else begin
                slots[n-1-k] = sh;
                hi--;
            end
        end
        if (known)
            pending_squares.push_back('{square: known_sq, run_end: 1'b1, overflowed: 1'b0});
        else
            for (int k = 0; k < n; k++)
                pending_squares.push_back('{square: slots[k], run_end: (k == n - 1),
                                            overflowed: run_dropped});
        run_count   = '0;
        run_dropped = 1'b0;
    endfunction

    // entered and left at a falling edge; valid stays up between back-to-back words
    task automatic send_word(input ssq_pkg::t_in_word w, input logic known,
                             input logic [SQUARE_W-1:0] known_sq);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        absorb_word(w, known, known_sq);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input int len, input bit sorted_run);
        int vals [$];
        int mode;
        ssq_pkg::t_in_word w;
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            case (mode)
                1: vals.push_back(int'($urandom_range(20)) - 10);
                2: case ($urandom_range(4))
                       0: vals.push_back(-32768);
                       1: vals.push_back(32767);
                       2: vals.push_back(-32767);
                       3: vals.push_back(0);
                       default: vals.push_back(int'($urandom_range(65535)) - 32768);
                   endcase
                default: vals.push_back(int'($urandom_range(65535)) - 32768);
            endcase
        end
        if (sorted_run)
            vals.sort();
        for (int i = 0; i < len; i++) begin
            w.value      = VALUE_W'(vals[i]);
            w.final_item = (i == len - 1);
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_squares.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic random_runs(input int upto);
        int len;
        int pick;
        while (words_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(1, 8);
            else if (pick < 94)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(63, 67);
            send_run(len, $urandom_range(99) >= 20);
            if ($urandom_range(99) < 8)
                drain_results();
        end
    endtask

    initial begin
        ssq_pkg::t_in_word w;
        int base;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        idle_pct     = 15;
        stall_pct    = 72;
        hold_reqs    = 0;
        mismatch_cnt = 0;
        words_sent   = 0;
        run_count    = '0;
        run_dropped  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            w.value      = DIR_TAB[r].value;
            w.final_item = DIR_TAB[r].fin;
            send_word(w, DIR_TAB[r].known, DIR_TAB[r].sq);
        end
        drain_results();

        base = words_sent;
        random_runs(base + RAND_ITEMS / 6);

        idle_pct  = 72;
        stall_pct = 15;
        random_runs(base + RAND_ITEMS / 3);

        idle_pct  = 0;
        stall_pct = 0;
        drain_results();
        // receiver holds off while a full run plus more words keep coming
        hold_reqs++;
        send_run(70, 1'b1);
        send_run(6, 1'b1);
        send_run(64, 1'b1);
        drain_results();
        send_run(65, 1'b0);
        random_runs(base + RAND_ITEMS);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && pending_squares.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        out_stall   = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_served) begin
                hold_served = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_squares.size() == 0) begin
                $error("result word with nothing expected: square %0d", o_out_word.square);
                mismatch_cnt++;
            end else begin
                want_word = pending_squares.pop_front();
                if (o_out_word.square !== want_word.square) begin
                    $error("square: expected %0d, got %0d", want_word.square,
                           o_out_word.square);
                    mismatch_cnt++;
                end
                if (o_out_word.run_end !== want_word.run_end) begin
                    $error("run_end: expected %0b, got %0b", want_word.run_end,
                           o_out_word.run_end);
                    mismatch_cnt++;
                end
                if (o_out_word.overflowed !== want_word.overflowed) begin
                    $error("overflowed: expected %0b, got %0b", want_word.overflowed,
                           o_out_word.overflowed);
                    mismatch_cnt++;
                end
            end
        end
    end

endmodule

// ===== sorted_squares_two_pointer_unit.f =====
src/ssq_pkg.sv
src/ssq_ram.sv
src/sorted_squares_two_pointer_unit.sv
sim/testbench.sv
